@@ hdl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/tmet_pkg.sv @@
// ----------------------------------------------------------------------------
// tmet_pkg
// Types and codes shared by the timer expiry table and its checker.
// ----------------------------------------------------------------------------
package tmet_pkg;

  localparam int ID_W   = 15;
  localparam int DUR_W  = 32;
  localparam int CMD_W  = 2;
  localparam int KIND_W = 3;

  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STOPPED   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd4;

  // One slot of the timer memory.
  typedef struct packed {
    logic             periodic;
    logic [ID_W-1:0]  id;
    logic [DUR_W-1:0] period;
    logic [DUR_W-1:0] remaining;
  } slot_entry_t;

endpackage

@@ hdl/multi_timer_expiry_table_top.sv @@
// ----------------------------------------------------------------------------
// multi_timer_expiry_table_top
// Table of SLOTS countdown timers: add, stop and tick requests, status and expiry reports.
//
//   channel | signals                                         | dir
//   in      | in_valid/in_ready, cmd, duration_ticks,         | in
//           | is_periodic, target_id                          |
//   out     | out_valid/out_ready, kind, timer_id, last        | out
//
// One request at a time. Tick and stop walk the slot memory one slot a cycle
// unless stalled, each slot read into a register before its update. Add scans
// the valid flops for the lowest free slot. Results go through a single output
// register; the walk pauses while it is full and not being taken. Reset clears
// the valid flops, next_id and the control flops; the slot memory is not reset.
// ----------------------------------------------------------------------------
module multi_timer_expiry_table_top #(
  parameter int SLOTS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tmet_pkg::CMD_W-1:0]   cmd,
  input  logic [tmet_pkg::DUR_W-1:0]   duration_ticks,
  input  logic                         is_periodic,
  input  logic [tmet_pkg::ID_W-1:0]    target_id,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tmet_pkg::KIND_W-1:0]  kind,
  output logic [tmet_pkg::ID_W-1:0]    timer_id,
  output logic                         last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_ADD  = 2'd2;

  logic [1:0] state;
  logic [tmet_pkg::CMD_W-1:0] cmd_q;
  logic [tmet_pkg::DUR_W-1:0] dur_q;
  logic                       per_q;
  logic [tmet_pkg::ID_W-1:0]  tgt_q;

  logic [SLOTS-1:0]           slot_valid;
  logic [tmet_pkg::ID_W-1:0]  next_id;
  logic [CNT_W-1:0]           cnt;
  logic                       p_vld;
  logic [IDX_W-1:0]           p_idx;
  logic                       pend_vld;
  logic [tmet_pkg::ID_W-1:0]  pend_id;

  tmet_pkg::slot_entry_t mem [SLOTS];
  tmet_pkg::slot_entry_t rdata;
  tmet_pkg::slot_entry_t wdata;
  logic                  mem_we;
  logic [IDX_W-1:0]      waddr;
  logic                  mem_re;

  logic                        out_free;
  logic                        push;
  logic [tmet_pkg::KIND_W-1:0] push_kind;
  logic [tmet_pkg::ID_W-1:0]   push_id;
  logic                        push_last;
  logic                        stall;
  logic                        walk_end;
  logic                        done;
  logic                        expire;
  logic                        p_live;
  logic                        clr_valid;
  logic                        set_valid;
  logic [IDX_W-1:0]            vidx;
  logic [IDX_W-1:0]            cnt_idx;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign cnt_idx  = cnt[IDX_W-1:0];
  assign p_live   = p_vld && slot_valid[p_idx];
  assign walk_end = (cnt == CNT_END) && !p_vld;

  always_comb begin
    push      = 1'b0;
    push_kind = tmet_pkg::KIND_ADDED;
    push_id   = '0;
    push_last = 1'b0;
    mem_we    = 1'b0;
    waddr     = p_idx;
    wdata     = rdata;
    stall     = 1'b0;
    done      = 1'b0;
    expire    = 1'b0;
    clr_valid = 1'b0;
    set_valid = 1'b0;
    vidx      = p_idx;
    case (state)
      S_WALK: begin
        if (walk_end) begin
          // end of walk: flush the held expiry, or report a missing id
          if (cmd_q == tmet_pkg::CMD_TICK) begin
            if (pend_vld) begin
              stall     = !out_free;
              push      = out_free;
              push_kind = tmet_pkg::KIND_EXPIRED;
              push_id   = pend_id;
              push_last = 1'b1;
            end
            done = !stall;
          end else begin
            stall     = !out_free;
            push      = out_free;
            push_kind = tmet_pkg::KIND_NOT_FOUND;
            push_last = 1'b1;
            done      = out_free;
          end
        end else if (cmd_q == tmet_pkg::CMD_TICK) begin
          if (p_live && (rdata.remaining <= tmet_pkg::DUR_W'(1))) begin
            // one expiry is held back so the final one can carry last
            if (pend_vld) begin
              stall     = !out_free;
              push      = out_free;
              push_kind = tmet_pkg::KIND_EXPIRED;
              push_id   = pend_id;
            end
            if (!stall) begin
              expire = 1'b1;
              if (rdata.periodic) begin
                mem_we          = 1'b1;
                wdata.remaining = rdata.period;
              end else begin
                clr_valid = 1'b1;
              end
            end
          end else if (p_live) begin
            mem_we          = 1'b1;
            wdata.remaining = rdata.remaining - tmet_pkg::DUR_W'(1);
          end
        end else begin
          if (p_live && (rdata.id == tgt_q)) begin
            stall     = !out_free;
            push      = out_free;
            push_kind = tmet_pkg::KIND_STOPPED;
            push_id   = tgt_q;
            push_last = 1'b1;
            clr_valid = out_free;
            done      = out_free;
          end
        end
      end
      S_ADD: begin
        vidx  = cnt_idx;
        waddr = cnt_idx;
        if (cnt == CNT_END) begin
          push      = out_free;
          push_kind = tmet_pkg::KIND_FULL;
          push_last = 1'b1;
          done      = out_free;
        end else if (!slot_valid[cnt_idx]) begin
          push            = out_free;
          push_kind       = tmet_pkg::KIND_ADDED;
          push_id         = next_id;
          push_last       = 1'b1;
          done            = out_free;
          set_valid       = out_free;
          mem_we          = out_free;
          wdata.periodic  = per_q;
          wdata.id        = next_id;
          wdata.period    = dur_q;
          wdata.remaining = dur_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign mem_re = (state == S_WALK) && !stall && !done && (cnt != CNT_END);

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[cnt_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      next_id    <= '0;
      cnt        <= '0;
      p_vld      <= 1'b0;
      pend_vld   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (clr_valid) begin
        slot_valid[vidx] <= 1'b0;
      end
      if (set_valid) begin
        slot_valid[vidx] <= 1'b1;
        next_id          <= next_id + tmet_pkg::ID_W'(1);
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cnt      <= '0;
            p_vld    <= 1'b0;
            pend_vld <= 1'b0;
            case (cmd)
              tmet_pkg::CMD_TICK: state <= S_WALK;
              tmet_pkg::CMD_STOP: state <= S_WALK;
              tmet_pkg::CMD_ADD:  state <= S_ADD;
              default:            state <= S_IDLE;
            endcase
          end
        end
        S_WALK: begin
          if (done) begin
            state    <= S_IDLE;
            p_vld    <= 1'b0;
            pend_vld <= 1'b0;
          end else if (!stall) begin
            if (expire) begin
              pend_vld <= 1'b1;
              pend_id  <= rdata.id;
            end
            p_vld <= (cnt != CNT_END);
            p_idx <= cnt_idx;
            if (cnt != CNT_END) begin
              cnt <= cnt + CNT_W'(1);
            end
          end
        end
        S_ADD: begin
          if (done) begin
            state <= S_IDLE;
          end else if ((cnt != CNT_END) && slot_valid[cnt_idx]) begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request fields and result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q <= cmd;
      dur_q <= duration_ticks;
      per_q <= is_periodic;
      tgt_q <= target_id;
    end
    if (push) begin
      kind     <= push_kind;
      timer_id <= push_id;
      last     <= push_last;
    end
  end

endmodule

@@ hdl/tmet_chk.sv @@
// ----------------------------------------------------------------------------
// tmet_chk
// Port-level checks on the timer expiry table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tmet_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tmet_pkg::KIND_W-1:0]  kind,
  input logic [tmet_pkg::ID_W-1:0]    timer_id,
  input logic                         last
);

  property p_out_hold;
    out_valid && !out_ready |=>
      out_valid && $stable(kind) && $stable(timer_id) && $stable(last);
  endproperty

  property p_single_last;
    out_valid && (kind != tmet_pkg::KIND_EXPIRED) |-> last;
  endproperty

  property p_zero_id;
    out_valid && (kind == tmet_pkg::KIND_FULL || kind == tmet_pkg::KIND_NOT_FOUND)
      |-> (timer_id == '0);
  endproperty

  property p_kind_range;
    out_valid |-> (kind <= tmet_pkg::KIND_EXPIRED);
  endproperty

  `ASSERT_ALWAYS(a_rst_clears_out, clk, rst |=> !out_valid, "output valid after reset")

  `ASSERT_CLK(a_out_hold, clk, rst, p_out_hold, "stalled result changed")

  `ASSERT_CLK(a_single_last, clk, rst, p_single_last, "add or stop result without last")

  `ASSERT_CLK(a_zero_id, clk, rst, p_zero_id, "nonzero id on full or not found")

  `ASSERT_CLK(a_kind_range, clk, rst, p_kind_range, "result kind out of range")

endmodule

bind multi_timer_expiry_table_top tmet_chk u_tmet_chk (.*);

@@ test/tb_multi_timer_expiry_table_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_timer_expiry_table_top
// Self-checking bench for the timer expiry table. A slot-level model predicts
// the added, full, stopped, not-found and expired reports of every accepted
// request; a monitor checks each in order. Stimulus: a directed opening,
// random traffic, a pass that clears the table and plants long timers, then
// more random traffic. The sender bursts, the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
import tmet_pkg::*;

typedef struct packed {
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   id;
  logic              last;
} timer_report_t;

class timer_table_model #(int NSLOTS = 16);
  bit                slot_live[NSLOTS];
  bit                slot_reload[NSLOTS];
  logic [ID_W-1:0]   slot_tid[NSLOTS];
  logic [DUR_W-1:0]  slot_len[NSLOTS];
  logic [DUR_W-1:0]  slot_left[NSLOTS];
  logic [ID_W-1:0]   id_next;
  timer_report_t     pending_reports[$];
  int                errors;

  function new();
    foreach (slot_live[i]) slot_live[i] = 1'b0;
    id_next = '0;
    errors  = 0;
  endfunction

  function void expect_report(logic [KIND_W-1:0] k, logic [ID_W-1:0] id, logic fin);
    timer_report_t r;
    r.kind = k;
    r.id   = id;
    r.last = fin;
    pending_reports.push_back(r);
  endfunction

  // Update the slot state for one accepted request and queue its reports.
  function void apply_request(logic [CMD_W-1:0] op, logic [DUR_W-1:0] dur, logic per,
                              logic [ID_W-1:0] tgt);
    int fired;
    int hit;
    fired = 0;
    hit   = -1;
    case (op)
      CMD_TICK: begin
        for (int i = 0; i < NSLOTS; i++) begin
          if (slot_live[i]) begin
            if (slot_left[i] <= 1) begin
              expect_report(KIND_EXPIRED, slot_tid[i], 1'b0);
              fired++;
              if (slot_reload[i]) slot_left[i] = slot_len[i];
              else slot_live[i] = 1'b0;
            end else begin
              slot_left[i] = slot_left[i] - 1;
            end
          end
        end
        if (fired > 0) pending_reports[pending_reports.size()-1].last = 1'b1;
      end
      CMD_ADD: begin
        for (int i = 0; i < NSLOTS; i++)
          if (!slot_live[i] && hit < 0) hit = i;
        if (hit < 0) begin
          expect_report(KIND_FULL, '0, 1'b1);
        end else begin
          slot_live[hit]   = 1'b1;
          slot_reload[hit] = per;
          slot_tid[hit]    = id_next;
          slot_len[hit]    = dur;
          slot_left[hit]   = dur;
          expect_report(KIND_ADDED, id_next, 1'b1);
          id_next = id_next + 1'b1;
        end
      end
      CMD_STOP: begin
        // duplicate ids: only the lowest slot goes
        for (int i = 0; i < NSLOTS; i++)
          if (slot_live[i] && slot_tid[i] == tgt && hit < 0) hit = i;
        if (hit < 0) begin
          expect_report(KIND_NOT_FOUND, '0, 1'b1);
        end else begin
          slot_live[hit] = 1'b0;
          expect_report(KIND_STOPPED, tgt, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  function void check_report(logic [KIND_W-1:0] k, logic [ID_W-1:0] id, logic fin);
    timer_report_t want;
    if (pending_reports.size() == 0) begin
      $display("%0t: unexpected report kind %0d id %0d last %0d", $time, k, id, fin);
      errors++;
      return;
    end
    want = pending_reports.pop_front();
    if (want.kind !== k) begin
      $display("%0t: kind mismatch: expected %0d, got %0d", $time, want.kind, k);
      errors++;
    end
    if (want.id !== id) begin
      $display("%0t: timer_id mismatch: expected %0d, got %0d", $time, want.id, id);
      errors++;
    end
    if (want.last !== fin) begin
      $display("%0t: last mismatch: expected %0d, got %0d", $time, want.last, fin);
      errors++;
    end
  endfunction

  function int free_slots();
    int n;
    n = 0;
    foreach (slot_live[i]) if (!slot_live[i]) n++;
    return n;
  endfunction

  function logic [ID_W-1:0] random_live_id();
    logic [ID_W-1:0] ids[$];
    foreach (slot_live[i]) if (slot_live[i]) ids.push_back(slot_tid[i]);
    if (ids.size() == 0) return ID_W'($urandom());
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  function int pending();
    return pending_reports.size();
  endfunction
endclass

module tb_multi_timer_expiry_table_top;
  localparam int SLOTS = 16;
  localparam int QUIET_CYCLES = 4 * SLOTS + 8;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CMD_W-1:0]   cmd = CMD_TICK;
  logic [DUR_W-1:0]   duration_ticks = '0;
  logic               is_periodic = 1'b0;
  logic [ID_W-1:0]    target_id = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [KIND_W-1:0]  kind;
  logic [ID_W-1:0]    timer_id;
  logic               last;

  int                 burst_left = 0;
  logic [15:0]        rx_pattern = 16'hFFFF;
  int                 rx_age = 0;
  timer_table_model #(SLOTS) timers;

  multi_timer_expiry_table_top #(.SLOTS(SLOTS)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .duration_ticks(duration_ticks), .is_periodic(is_periodic),
    .target_id(target_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .timer_id(timer_id), .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: rotating ready pattern, reloaded now and then.
  always @(posedge clk) begin
    if (rx_age == 0) begin
      case ($urandom_range(0, 3))
        0: rx_pattern = 16'hFFFF;
        1: rx_pattern = 16'($urandom() & $urandom()) | 16'h1;
        default: rx_pattern = 16'($urandom()) | 16'h1;
      endcase
      rx_age = $urandom_range(16, 80);
    end else begin
      rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
      rx_age--;
    end
    out_ready <= rx_pattern[0];
  end

  always @(posedge clk)
    if (!rst && out_valid && out_ready) timers.check_report(kind, timer_id, last);

  task automatic send_request(input logic [CMD_W-1:0] op, input logic [DUR_W-1:0] dur,
                              input logic per, input logic [ID_W-1:0] tgt);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(9, 30);
      else gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid       <= 1'b1;
    cmd            <= op;
    duration_ticks <= dur;
    is_periodic    <= per;
    target_id      <= tgt;
    do @(posedge clk); while (!in_ready);
    timers.apply_request(op, dur, per, tgt);
  endtask

  // Mostly well-formed traffic; stops usually aim at a live id.
  task automatic random_traffic(input int count);
    int done;
    int pick;
    logic [CMD_W-1:0] op;
    logic [DUR_W-1:0] dur;
    logic per;
    logic [ID_W-1:0] tgt;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      dur  = $urandom();
      per  = 1'($urandom_range(0, 1));
      tgt  = ID_W'($urandom());
      if (pick < 6) begin
        op = CMD_UNUSED;
      end else if (pick < 40) begin
        op = CMD_TICK;
      end else if (pick < 75) begin
        op = CMD_ADD;
        case ($urandom_range(0, 9))
          7: dur = $urandom_range(7, 40);
          8: ;
          9: dur = '1;
          default: dur = $urandom_range(0, 6);
        endcase
      end else begin
        op = CMD_STOP;
        if ($urandom_range(0, 4) != 0) tgt = timers.random_live_id();
      end
      send_request(op, dur, per, tgt);
      if (op != CMD_UNUSED) done++;
    end
  endtask

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [ID_W-1:0] planted_id;
    timers = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty table, unknown command
    send_request(CMD_STOP, '0, 1'b0, '0);
    send_request(CMD_TICK, '1, 1'b1, '1);
    send_request(CMD_UNUSED, $urandom(), 1'b1, 15'h7FFF);
    // fill every slot: zero, one and max durations, both modes
    send_request(CMD_ADD, 32'd0, 1'b0, '0);
    send_request(CMD_ADD, 32'd1, 1'b0, '0);
    send_request(CMD_ADD, 32'd2, 1'b1, '0);
    send_request(CMD_ADD, 32'd0, 1'b1, '0);
    send_request(CMD_ADD, 32'd1, 1'b1, '0);
    send_request(CMD_ADD, '1, 1'b0, '0);
    send_request(CMD_ADD, '1, 1'b1, '0);
    for (int i = 7; i < SLOTS; i++)
      send_request(CMD_ADD, $urandom_range(1, 5), 1'($urandom_range(0, 1)), '0);
    send_request(CMD_ADD, 32'h5A5A_5A5A, 1'b1, '0);
    send_request(CMD_TICK, '0, 1'b0, '0);
    send_request(CMD_STOP, '0, 1'b0, 15'd6);
    send_request(CMD_STOP, '0, 1'b0, 15'd6);
    send_request(CMD_STOP, '0, 1'b0, 15'h7FFF);
    send_request(CMD_TICK, '0, 1'b0, '0);

    random_traffic(200);

    // Clear the table, then plant long timers.
    while (timers.free_slots() < SLOTS)
      send_request(CMD_STOP, $urandom(), 1'($urandom_range(0, 1)),
                   timers.random_live_id());
    planted_id = timers.id_next;
    send_request(CMD_ADD, '1, 1'b0, '0);
    send_request(CMD_ADD, '1, 1'b1, '0);
    send_request(CMD_ADD, 32'hFFFF_FFFE, 1'b0, '0);
    send_request(CMD_TICK, '0, 1'b0, '0);

    // stop a live id, then the same id once it is gone
    send_request(CMD_ADD, 32'd3, 1'b1, '0);
    send_request(CMD_STOP, '0, 1'b0, planted_id);
    send_request(CMD_STOP, '0, 1'b0, planted_id);
    send_request(CMD_STOP, '0, 1'b0, planted_id);

    random_traffic(200);

    in_valid <= 1'b0;
    while (timers.pending() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    if (timers.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+hdl
hdl/tmet_pkg.sv
hdl/multi_timer_expiry_table_top.sv
hdl/tmet_chk.sv
test/tb_multi_timer_expiry_table_top.sv
